// ===== hdl/bcru_pkg.sv =====
// ----------------------------------------------------------------------------
// bcru_pkg
// Shared types and constants of the bounded composition rank/unrank coder.
// ----------------------------------------------------------------------------
package bcru_pkg;

   localparam int MAX_PARTS_DEF      = 8;
   localparam int MAX_PART_VALUE_DEF = 16;

   localparam int PART_FIELDS = 8;
   localparam int PART_W      = 5;
   localparam int NUM_PARTS_W = 4;
   localparam int RANK_W      = 32;
   localparam int TOTAL_W     = 8;
   localparam int J_W         = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_PARTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PART  = 2'd1;

   localparam logic [3:0] NUM_PARTS_RESET = 4'd4;
   localparam logic [4:0] MAX_PART_RESET  = 5'd7;

   localparam logic KIND_RANK   = 1'b0;
   localparam logic KIND_UNRANK = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [PART_W-1:0]   part_0;
      logic [PART_W-1:0]   part_1;
      logic [PART_W-1:0]   part_2;
      logic [PART_W-1:0]   part_3;
      logic [PART_W-1:0]   part_4;
      logic [PART_W-1:0]   part_5;
      logic [PART_W-1:0]   part_6;
      logic [PART_W-1:0]   part_7;
      logic [RANK_W-1:0]   rank_in;
      logic [TOTAL_W-1:0]  total;
   } req_word_type;

   typedef struct packed {
      logic [RANK_W-1:0]   rank_out;
      logic [PART_W-1:0]   part_out_0;
      logic [PART_W-1:0]   part_out_1;
      logic [PART_W-1:0]   part_out_2;
      logic [PART_W-1:0]   part_out_3;
      logic [PART_W-1:0]   part_out_4;
      logic [PART_W-1:0]   part_out_5;
      logic [PART_W-1:0]   part_out_6;
      logic [PART_W-1:0]   part_out_7;
      logic [TOTAL_W-1:0]  sum_out;
      logic                error;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_BUILD_INIT,
      ST_BUILD,
      ST_BUILD_DRAIN,
      ST_IDLE,
      ST_CHECK,
      ST_RANK,
      ST_CHK_WAIT,
      ST_UNR,
      ST_UNR_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_BUILD_INIT,
      OP_BUILD_STEP,
      OP_LOAD,
      OP_RANK_STEP,
      OP_CHK_RD,
      OP_SET_ERR,
      OP_UNR_RD,
      OP_UNR_EVAL,
      OP_UNR_TAKE,
      OP_UNR_LAST,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic build_last;
      logic is_unrank;
      logic err;
      logic parts_done;
      logic chk_bad;
      logic unr_at_k;
   } dp_status_type;

endpackage

// ===== hdl/bcru_ram.sv =====
// ----------------------------------------------------------------------------
// bcru_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bcru_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/bcru_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcru_ctrl
// Sequencer: table build, rank walk, unrank walk and result emit.
// ----------------------------------------------------------------------------
module bcru_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start_fire,
   input  logic                   cfg_fire,
   input  bcru_pkg::dp_status_type status,
   output bcru_pkg::dp_cmd_type    cmd,
   output logic                   idle
);
   import bcru_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BUILD_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      idle     = 1'b0;
      unique case (state_ff)
         ST_BUILD_INIT: begin
            cmd.op   = OP_BUILD_INIT;
            state_in = ST_BUILD;
         end
         ST_BUILD: begin
            cmd.op = OP_BUILD_STEP;
            if (status.build_last) begin
               state_in = ST_BUILD_DRAIN;
            end
         end
         ST_BUILD_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            idle = 1'b1;
            priority if (cfg_fire) begin
               state_in = ST_BUILD_INIT;
            end else if (start_fire) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.err) begin
               state_in = ST_EMIT;
            end else if (!status.is_unrank) begin
               state_in = ST_RANK;
            end else begin
               cmd.op   = OP_CHK_RD;
               state_in = ST_CHK_WAIT;
            end
         end
         ST_RANK: begin
            if (status.parts_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.op = OP_RANK_STEP;
            end
         end
         ST_CHK_WAIT: begin
            if (status.chk_bad) begin
               cmd.op   = OP_SET_ERR;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_UNR;
            end
         end
         ST_UNR: begin
            priority if (status.parts_done) begin
               cmd.op   = OP_UNR_LAST;
               state_in = ST_EMIT;
            end else if (status.unr_at_k) begin
               cmd.op = OP_UNR_TAKE;
            end else begin
               cmd.op   = OP_UNR_RD;
               state_in = ST_UNR_WAIT;
            end
         end
         ST_UNR_WAIT: begin
            cmd.op   = OP_UNR_EVAL;
            state_in = ST_UNR;
         end
         ST_EMIT: begin
            cmd.op   = OP_EMIT;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_BUILD_INIT;
         end
      endcase
   end

endmodule

// ===== hdl/bcru_dp.sv =====
// ----------------------------------------------------------------------------
// bcru_dp
// Datapath: config registers, count table build, rank and unrank arithmetic.
// ----------------------------------------------------------------------------
module bcru_dp #(
   parameter int MAX_PARTS      = bcru_pkg::MAX_PARTS_DEF,
   parameter int MAX_PART_VALUE = bcru_pkg::MAX_PART_VALUE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr,
   input  logic [bcru_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bcru_pkg::CSR_DATA_W-1:0]     csr_data,
   input  bcru_pkg::req_word_type              req_word,
   input  bcru_pkg::dp_cmd_type                cmd,
   output bcru_pkg::dp_status_type             status,
   output logic                                rsp_valid,
   output bcru_pkg::rsp_word_type              rsp_word
);
   import bcru_pkg::*;

   localparam int DMAX     = (MAX_PARTS < PART_FIELDS) ? MAX_PARTS : PART_FIELDS;
   localparam int SUM_COLS = MAX_PARTS * MAX_PART_VALUE + 1;
   localparam int CW       = $clog2(SUM_COLS);
   localparam int RW       = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int AW       = RW + CW;
   localparam int DEPTH    = 1 << AW;
   localparam int KW       = $clog2(MAX_PART_VALUE + 1);
   localparam int VW       = ((CW > TOTAL_W) ? CW : TOTAL_W) + 2;

   // configuration
   logic [NUM_PARTS_W-1:0] d_raw_ff, d_raw_in;
   logic [4:0]             k_raw_ff, k_raw_in;
   logic [NUM_PARTS_W-1:0] d_eff;
   logic [KW-1:0]          k_eff;

   // item registers
   logic                   kind_ff, kind_in;
   logic [PART_W-1:0]      parts_ff [PART_FIELDS];
   logic [PART_W-1:0]      parts_in [PART_FIELDS];
   logic [PART_W-1:0]      outp_ff  [PART_FIELDS];
   logic [PART_W-1:0]      outp_in  [PART_FIELDS];
   logic [RANK_W-1:0]      idx_ff, idx_in;
   logic [RANK_W-1:0]      rank_in_ff, rank_in_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [TOTAL_W-1:0]     sum_ff, sum_in;
   logic                   err_ff, err_in;
   logic [RANK_W-1:0]      acc_ff, acc_in;
   logic [J_W-1:0]         j_ff, j_in;
   logic [PART_W-1:0]      i_ff, i_in;
   logic [KW-1:0]          v_ff, v_in;
   logic signed [VW-1:0]   rem_ff, rem_in;
   logic                   r_vld_ff, r_vld_in;
   logic                   z_zero_ff, z_zero_in;

   // table build
   logic [RW-1:0]          b_row_ff, b_row_in;
   logic [CW-1:0]          b_col_ff, b_col_in;
   logic                   p_vld_ff, p_vld_in;
   logic [RW-1:0]          p_row_ff, p_row_in;
   logic [CW-1:0]          p_col_ff, p_col_in;
   logic                   p_a_ff, p_a_in;
   logic                   p_b_ff, p_b_in;
   logic [RANK_W-1:0]      bacc_ff, bacc_in;

   // output register
   logic                   rv_ff, rv_in;
   rsp_word_type           rw_ff, rw_in;

   // memory ports
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [RANK_W-1:0]      wr_data;
   logic [AW-1:0]          rd_addr_a, rd_addr_b;
   logic [RANK_W-1:0]      rd_data_a, rd_data_b;

   // helpers
   logic [PART_W-1:0]      req_parts [PART_FIELDS];
   logic [4:0]             row_walk;
   logic [4:0]             row_chk;
   logic [PART_W-1:0]      pj;
   logic signed [VW-1:0]   rem_min_i;
   logic signed [VW-1:0]   rem_min_v;
   logic [VW-1:0]          col_w;
   logic [VW-1:0]          kd;
   logic                   part_bad;
   logic [TOTAL_W-1:0]     part_sum;
   logic [RANK_W-1:0]      z;
   logic [RANK_W-1:0]      base;

   bcru_ram #(
      .WIDTH (RANK_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // saturate config registers to the legal range
   always_comb begin
      priority if (d_raw_ff == '0) begin
         d_eff = NUM_PARTS_W'(1);
      end else if (d_raw_ff > NUM_PARTS_W'(DMAX)) begin
         d_eff = NUM_PARTS_W'(DMAX);
      end else begin
         d_eff = d_raw_ff;
      end
      priority if (k_raw_ff == '0) begin
         k_eff = KW'(1);
      end else if (VW'(k_raw_ff) > VW'(MAX_PART_VALUE)) begin
         k_eff = KW'(MAX_PART_VALUE);
      end else begin
         k_eff = KW'(k_raw_ff);
      end
   end

   assign req_parts[0] = req_word.part_0;
   assign req_parts[1] = req_word.part_1;
   assign req_parts[2] = req_word.part_2;
   assign req_parts[3] = req_word.part_3;
   assign req_parts[4] = req_word.part_4;
   assign req_parts[5] = req_word.part_5;
   assign req_parts[6] = req_word.part_6;
   assign req_parts[7] = req_word.part_7;

   // range check and sum of the incoming parts
   always_comb begin
      part_bad = 1'b0;
      part_sum = '0;
      for (int n = 0; n < PART_FIELDS; n++) begin
         if (NUM_PARTS_W'(n) < d_eff) begin
            if (req_parts[n] == '0 || VW'(req_parts[n]) > VW'(k_eff)) begin
               part_bad = 1'b1;
            end
            part_sum = part_sum + TOTAL_W'(req_parts[n]);
         end
      end
   end

   assign kd        = VW'(k_eff) * VW'(d_eff);
   assign row_walk  = 5'(d_eff) - 5'(j_ff) - 5'd2;
   assign row_chk   = 5'(d_eff) - 5'd1;
   assign pj        = parts_ff[j_ff];
   assign rem_min_i = rem_ff - VW'(i_ff);
   assign rem_min_v = rem_ff - VW'(v_ff);
   assign col_w     = VW'(b_col_ff);
   assign z         = z_zero_ff ? '0 : rd_data_a;
   assign base      = (p_col_ff == '0) ? '0 : bacc_ff;

   always_comb begin
      status.build_last = (b_row_ff == RW'(MAX_PARTS - 1)) &&
                          (b_col_ff == CW'(SUM_COLS - 1));
      status.is_unrank  = kind_ff;
      status.err        = err_ff;
      status.parts_done = (NUM_PARTS_W'(j_ff) == d_eff - NUM_PARTS_W'(1));
      status.chk_bad    = idx_ff >= rd_data_a;
      status.unr_at_k   = v_ff >= k_eff;
   end

   always_comb begin
      d_raw_in   = d_raw_ff;
      k_raw_in   = k_raw_ff;
      kind_in    = kind_ff;
      parts_in   = parts_ff;
      outp_in    = outp_ff;
      idx_in     = idx_ff;
      rank_in_in = rank_in_ff;
      total_in   = total_ff;
      sum_in     = sum_ff;
      err_in     = err_ff;
      acc_in     = acc_ff;
      j_in       = j_ff;
      i_in       = i_ff;
      v_in       = v_ff;
      rem_in     = rem_ff;
      r_vld_in   = 1'b0;
      z_zero_in  = z_zero_ff;
      b_row_in   = b_row_ff;
      b_col_in   = b_col_ff;
      p_vld_in   = 1'b0;
      p_row_in   = p_row_ff;
      p_col_in   = p_col_ff;
      p_a_in     = 1'b0;
      p_b_in     = 1'b0;
      bacc_in    = bacc_ff;
      rv_in      = 1'b0;
      rw_in      = rw_ff;
      rd_addr_a  = '0;
      rd_addr_b  = '0;

      if (csr_wr) begin
         unique case (csr_index)
            REG_NUM_PARTS: d_raw_in = csr_data[NUM_PARTS_W-1:0];
            REG_MAX_PART:  k_raw_in = csr_data[4:0];
            default: ;
         endcase
      end

      // accumulate a rank read issued in the previous cycle
      if (r_vld_ff) begin
         acc_in = acc_ff + rd_data_a;
      end

      // build write stage
      wr_en   = p_vld_ff;
      wr_addr = {p_row_ff, p_col_ff};
      if (p_row_ff == '0) begin
         wr_data = RANK_W'((p_col_ff != '0) && (VW'(p_col_ff) <= VW'(k_eff)));
      end else begin
         wr_data = base + (p_a_ff ? rd_data_a : '0) - (p_b_ff ? rd_data_b : '0);
      end
      if (p_vld_ff) begin
         bacc_in = wr_data;
      end

      unique case (cmd.op)
         OP_BUILD_INIT: begin
            b_row_in = '0;
            b_col_in = '0;
         end
         OP_BUILD_STEP: begin
            p_vld_in  = 1'b1;
            p_row_in  = b_row_ff;
            p_col_in  = b_col_ff;
            p_a_in    = (b_row_ff != '0) && (b_col_ff != '0);
            p_b_in    = (b_row_ff != '0) && (col_w > VW'(k_eff));
            rd_addr_a = {RW'(b_row_ff - RW'(1)), CW'(col_w - VW'(1))};
            rd_addr_b = {RW'(b_row_ff - RW'(1)), CW'(col_w - VW'(1) - VW'(k_eff))};
            if (b_col_ff == CW'(SUM_COLS - 1)) begin
               b_col_in = '0;
               b_row_in = b_row_ff + RW'(1);
            end else begin
               b_col_in = b_col_ff + CW'(1);
            end
         end
         OP_LOAD: begin
            kind_in    = req_word.kind;
            parts_in   = req_parts;
            idx_in     = req_word.rank_in;
            rank_in_in = req_word.rank_in;
            total_in   = req_word.total;
            sum_in     = part_sum;
            acc_in     = '0;
            j_in       = '0;
            i_in       = PART_W'(1);
            v_in       = KW'(1);
            for (int n = 0; n < PART_FIELDS; n++) begin
               outp_in[n] = '0;
            end
            if (req_word.kind == KIND_RANK) begin
               err_in = part_bad;
               rem_in = VW'(part_sum);
            end else begin
               err_in = (VW'(req_word.total) < VW'(d_eff)) || (VW'(req_word.total) > kd);
               rem_in = VW'(req_word.total);
            end
         end
         OP_RANK_STEP: begin
            if (i_ff < pj) begin
               rd_addr_a = {RW'(row_walk), CW'(rem_min_i)};
               r_vld_in  = 1'b1;
               i_in      = i_ff + PART_W'(1);
            end else begin
               rem_in = rem_ff - VW'(pj);
               j_in   = j_ff + J_W'(1);
               i_in   = PART_W'(1);
            end
         end
         OP_CHK_RD: begin
            rd_addr_a = {RW'(row_chk), CW'(total_ff)};
         end
         OP_SET_ERR: begin
            err_in = 1'b1;
         end
         OP_UNR_RD: begin
            rd_addr_a = {RW'(row_walk), CW'(rem_min_v)};
            z_zero_in = rem_min_v[VW-1];
         end
         OP_UNR_EVAL: begin
            if (z > idx_ff) begin
               outp_in[j_ff] = PART_W'(v_ff);
               rem_in        = rem_min_v;
               j_in          = j_ff + J_W'(1);
               v_in          = KW'(1);
            end else begin
               idx_in = idx_ff - z;
               v_in   = v_ff + KW'(1);
            end
         end
         OP_UNR_TAKE: begin
            outp_in[j_ff] = PART_W'(v_ff);
            rem_in        = rem_min_v;
            j_in          = j_ff + J_W'(1);
            v_in          = KW'(1);
         end
         OP_UNR_LAST: begin
            outp_in[j_ff] = rem_ff[VW-1] ? '0 : PART_W'(rem_ff);
         end
         OP_EMIT: begin
            rv_in = 1'b1;
            rw_in = '0;
            priority if (err_ff) begin
               rw_in.error = 1'b1;
            end else if (kind_ff == KIND_RANK) begin
               rw_in.rank_out = acc_ff;
               rw_in.sum_out  = sum_ff;
            end else begin
               rw_in.rank_out   = rank_in_ff;
               rw_in.sum_out    = total_ff;
               rw_in.part_out_0 = outp_ff[0];
               rw_in.part_out_1 = outp_ff[1];
               rw_in.part_out_2 = outp_ff[2];
               rw_in.part_out_3 = outp_ff[3];
               rw_in.part_out_4 = outp_ff[4];
               rw_in.part_out_5 = outp_ff[5];
               rw_in.part_out_6 = outp_ff[6];
               rw_in.part_out_7 = outp_ff[7];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_raw_ff <= NUM_PARTS_RESET;
         k_raw_ff <= MAX_PART_RESET;
         p_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         d_raw_ff <= d_raw_in;
         k_raw_ff <= k_raw_in;
         p_vld_ff <= p_vld_in;
         r_vld_ff <= r_vld_in;
         rv_ff    <= rv_in;
      end
      kind_ff    <= kind_in;
      parts_ff   <= parts_in;
      outp_ff    <= outp_in;
      idx_ff     <= idx_in;
      rank_in_ff <= rank_in_in;
      total_ff   <= total_in;
      sum_ff     <= sum_in;
      err_ff     <= err_in;
      acc_ff     <= acc_in;
      j_ff       <= j_in;
      i_ff       <= i_in;
      v_ff       <= v_in;
      rem_ff     <= rem_in;
      z_zero_ff  <= z_zero_in;
      b_row_ff   <= b_row_in;
      b_col_ff   <= b_col_in;
      p_row_ff   <= p_row_in;
      p_col_ff   <= p_col_in;
      p_a_ff     <= p_a_in;
      p_b_ff     <= p_b_in;
      bacc_ff    <= bacc_in;
      rw_ff      <= rw_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_word  = rw_ff;

endmodule

// ===== hdl/bounded_composition_rank_unrank.sv =====
// ----------------------------------------------------------------------------
// bounded_composition_rank_unrank
// Enumerative coder for vectors of d parts in 1..k: rank parts to an index
// among vectors of equal sum, or unrank an index and sum back to parts.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 word             direction
//   req       start / busy              req_word_type    in
//   rsp       rsp_valid (strobe)        rsp_word_type    out
//   csr       csr_valid / csr_ready     csr_index, data  in
//
// Steps: rank walks the first d-1 parts, issuing a table read for each value
//   below the part and then a step to advance past it. Unrank waits on each
//   table read before judging it, and takes a part that reaches k without a
//   read; the last part is what remains of the sum.
// Reset and each write to a known register rebuild the count table, one
//   entry per cycle, with busy high.
// Stalls: none on the result side; a result stands for one cycle.
// ----------------------------------------------------------------------------
module bounded_composition_rank_unrank #(
   parameter int MAX_PARTS      = bcru_pkg::MAX_PARTS_DEF,
   parameter int MAX_PART_VALUE = bcru_pkg::MAX_PART_VALUE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  bcru_pkg::req_word_type          req_word,
   output logic                            rsp_valid,
   output bcru_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bcru_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcru_pkg::CSR_DATA_W-1:0] csr_data
);
   import bcru_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          idle;
   logic          start_fire;
   logic          csr_wr;
   logic          cfg_fire;

   // hold items off while a register write is offered, so the two never meet
   assign busy       = !idle || csr_valid;
   assign csr_ready  = idle;
   assign start_fire = start && !busy;
   assign csr_wr     = csr_valid && csr_ready;
   // rebuild only for a known register; drop writes beyond the list
   assign cfg_fire   = csr_wr && ((csr_index == REG_NUM_PARTS) || (csr_index == REG_MAX_PART));

   bcru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start_fire (start_fire),
      .cfg_fire   (cfg_fire),
      .status     (status),
      .cmd        (cmd),
      .idle       (idle)
   );

   bcru_dp #(
      .MAX_PARTS      (MAX_PARTS),
      .MAX_PART_VALUE (MAX_PART_VALUE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_wr),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // a result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // an accepted word keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start_fire |=> busy)
      else $error("block not busy after accepting a word");

   // a write to a known register starts a table rebuild
   a_cfg_rebuild: assert property (@(posedge clock) disable iff (reset)
      cfg_fire |=> busy)
      else $error("no rebuild after register write");

   // an error result carries nothing else
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.error) |-> (rsp_word.rank_out == '0 && rsp_word.sum_out == '0))
      else $error("error result with nonzero fields");

   // no result while the table is being built
   a_no_rsp_in_build: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_BUILD_STEP) |-> !rsp_valid)
      else $error("result during table build");

endmodule

// ===== test/bcru_checker.sv =====
// ----------------------------------------------------------------------------
// bcru_checker
// Watches the request, result and register channels of the composition coder.
// Keeps its own count table and register copy, predicts each result word and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bcru_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  bcru_pkg::req_word_type          req_word,
   input  logic                            rsp_valid,
   input  bcru_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [bcru_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcru_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              pending,
   output int                              fail_count
);
   import bcru_pkg::*;

   localparam int SUM_MAX = MAX_PARTS_DEF * MAX_PART_VALUE_DEF;

   longint       tally [1:MAX_PARTS_DEF][0:SUM_MAX];
   logic [3:0]   parts_reg;
   logic [4:0]   limit_reg;
   rsp_word_type answers [$];

   function automatic int eff_parts();
      int d;
      d = parts_reg;
      if (d < 1) d = 1;
      if (d > MAX_PARTS_DEF) d = MAX_PARTS_DEF;
      return d;
   endfunction

   function automatic int eff_limit();
      int k;
      k = limit_reg;
      if (k < 1) k = 1;
      if (k > MAX_PART_VALUE_DEF) k = MAX_PART_VALUE_DEF;
      return k;
   endfunction

   function automatic longint look(int dd, int v);
      if (dd < 1 || dd > MAX_PARTS_DEF || v < 0 || v > SUM_MAX) return 0;
      return tally[dd][v];
   endfunction

   task automatic rebuild_tally();
      int     k;
      longint acc;
      k = eff_limit();
      for (int dd = 1; dd <= MAX_PARTS_DEF; dd++)
         for (int v = 0; v <= SUM_MAX; v++) tally[dd][v] = 0;
      for (int v = 1; v <= k; v++) tally[1][v] = 1;
      for (int dd = 2; dd <= MAX_PARTS_DEF; dd++)
         for (int v = 0; v <= SUM_MAX; v++) begin
            acc = 0;
            for (int i = 1; i <= k; i++) acc += look(dd - 1, v - i);
            tally[dd][v] = acc & 64'hFFFF_FFFF;
         end
   endtask

   function automatic rsp_word_type code_word(req_word_type w);
      rsp_word_type r;
      int           p [PART_FIELDS];
      int           outp [PART_FIELDS];
      int           d, k, sum, rem, v;
      longint       rank, idx, z;
      d = eff_parts();
      k = eff_limit();
      r = '0;
      for (int j = 0; j < PART_FIELDS; j++) outp[j] = 0;
      p[0] = w.part_0; p[1] = w.part_1; p[2] = w.part_2; p[3] = w.part_3;
      p[4] = w.part_4; p[5] = w.part_5; p[6] = w.part_6; p[7] = w.part_7;
      if (w.kind == KIND_RANK) begin
         sum = 0;
         for (int j = 0; j < d; j++) begin
            if (p[j] < 1 || p[j] > k) begin
               r.error = 1'b1;
               return r;
            end
            sum += p[j];
         end
         rank = 0;
         rem  = sum;
         for (int j = 0; j < d - 1; j++) begin
            for (int i = 1; i < p[j]; i++) rank += look(d - j - 1, rem - i);
            rem -= p[j];
         end
         r.rank_out = rank[31:0];
         r.sum_out  = sum[7:0];
         return r;
      end
      idx = w.rank_in;
      sum = w.total;
      if (sum < d || sum > k * d || idx >= look(d, sum)) begin
         r.error = 1'b1;
         return r;
      end
      rem = sum;
      for (int j = 0; j < d - 1; j++) begin
         v = 1;
         while (v < k) begin
            z = look(d - j - 1, rem - v);
            if (z > idx) break;
            idx -= z;
            v++;
         end
         outp[j] = v;
         rem -= v;
      end
      outp[d - 1] = (rem < 0) ? 0 : rem;
      r.part_out_0 = outp[0][4:0]; r.part_out_1 = outp[1][4:0];
      r.part_out_2 = outp[2][4:0]; r.part_out_3 = outp[3][4:0];
      r.part_out_4 = outp[4][4:0]; r.part_out_5 = outp[5][4:0];
      r.part_out_6 = outp[6][4:0]; r.part_out_7 = outp[7][4:0];
      r.rank_out   = w.rank_in;
      r.sum_out    = w.total;
      return r;
   endfunction

   task automatic match(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      parts_reg  = NUM_PARTS_RESET;
      limit_reg  = MAX_PART_RESET;
      rebuild_tally();
   end

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         parts_reg = NUM_PARTS_RESET;
         limit_reg = MAX_PART_RESET;
         rebuild_tally();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_NUM_PARTS) begin
               parts_reg = csr_data[3:0];
               rebuild_tally();
            end else if (csr_index == REG_MAX_PART) begin
               limit_reg = csr_data[4:0];
               rebuild_tally();
            end
         end
         if (start && !busy) answers.push_back(code_word(req_word));
         if (rsp_valid) begin
            if (answers.size() == 0) begin
               $error("result word with no request outstanding");
               fail_count++;
            end else begin
               e = answers.pop_front();
               match("rank_out",   e.rank_out,   rsp_word.rank_out);
               match("part_out_0", e.part_out_0, rsp_word.part_out_0);
               match("part_out_1", e.part_out_1, rsp_word.part_out_1);
               match("part_out_2", e.part_out_2, rsp_word.part_out_2);
               match("part_out_3", e.part_out_3, rsp_word.part_out_3);
               match("part_out_4", e.part_out_4, rsp_word.part_out_4);
               match("part_out_5", e.part_out_5, rsp_word.part_out_5);
               match("part_out_6", e.part_out_6, rsp_word.part_out_6);
               match("part_out_7", e.part_out_7, rsp_word.part_out_7);
               match("sum_out",    e.sum_out,    rsp_word.sum_out);
               match("error",      e.error,      rsp_word.error);
            end
         end
      end
      pending = answers.size();
   end

endmodule

// ===== test/bounded_composition_rank_unrank_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_composition_rank_unrank_tb
// Drives rank and unrank words through the composition coder under several
// register settings, with bursty start traffic; the checker judges results.
// ----------------------------------------------------------------------------
module bounded_composition_rank_unrank_tb;
   import bcru_pkg::*;

   // indexes past the two real registers; the block must ignore them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   rsp_word_type          rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    pending;
   int                    fail_count;
   int                    cycles = 0;

   // our own view of the effective registers, used only to shape stimulus
   int cur_parts = 4;
   int cur_limit = 7;
   int burst_left = 0;

   always #5 clock = ~clock;

   bounded_composition_rank_unrank u_dut (
      .clock, .reset, .start, .busy, .req_word, .rsp_valid, .rsp_word,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   bcru_checker u_checker (
      .clock, .reset, .start, .busy, .req_word, .rsp_valid, .rsp_word,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .pending, .fail_count
   );

   // watchdog: a hung block ends the run as a failure
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // vectors of d parts in 1..k summing to s, for picking legal indexes
   function automatic longint vector_count(int d, int k, int s);
      longint row [0:255];
      longint nxt [0:255];
      for (int v = 0; v < 256; v++) row[v] = (v >= 1 && v <= k) ? 1 : 0;
      for (int dd = 2; dd <= d; dd++) begin
         for (int v = 0; v < 256; v++) begin
            nxt[v] = 0;
            for (int i = 1; i <= k && i <= v; i++) nxt[v] += row[v - i];
            nxt[v] &= 64'hFFFF_FFFF;
         end
         row = nxt;
      end
      return (s >= 0 && s < 256) ? row[s] : 0;
   endfunction

   function automatic req_word_type noise_word();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_word_type)-1:0];
   endfunction

   // random parts within range; unused parts get any value
   function automatic req_word_type legal_parts(req_word_type w);
      logic [4:0] p [PART_FIELDS];
      for (int j = 0; j < PART_FIELDS; j++)
         p[j] = (j < cur_parts) ? 5'($urandom_range(1, cur_limit)) : 5'($urandom);
      w.part_0 = p[0]; w.part_1 = p[1]; w.part_2 = p[2]; w.part_3 = p[3];
      w.part_4 = p[4]; w.part_5 = p[5]; w.part_6 = p[6]; w.part_7 = p[7];
      return w;
   endfunction

   function automatic int parts_sum(req_word_type w);
      int s;
      s = w.part_0 + w.part_1 + w.part_2 + w.part_3;
      s += w.part_4 + w.part_5 + w.part_6 + w.part_7;
      for (int j = cur_parts; j < PART_FIELDS; j++)
         s -= (j == 4) ? w.part_4 : (j == 5) ? w.part_5 : (j == 6) ? w.part_6 :
              (j == 7) ? w.part_7 : (j == 1) ? w.part_1 : (j == 2) ? w.part_2 :
              w.part_3;
      return s;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      longint       cnt;
      int           pick, bad;
      w    = legal_parts(noise_word());
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
         w.kind = KIND_RANK;
      end else if (pick <= 7) begin
         w.kind  = KIND_UNRANK;
         w.total = 8'(parts_sum(w));
         cnt     = vector_count(cur_parts, cur_limit, w.total);
         case ($urandom_range(0, 5))
            0:       w.rank_in = 0;
            1:       w.rank_in = 32'(cnt - 1);
            2:       w.rank_in = 32'(cnt);
            default: w.rank_in = 32'({$urandom, $urandom} % cnt);
         endcase
      end else if (pick == 8) begin
         // break one used part: zero, just above k, or anything
         w.kind = KIND_RANK;
         bad = $urandom_range(0, cur_parts - 1);
         case (bad)
            0: w.part_0 = 0;
            1: w.part_1 = 5'(cur_limit + 1);
            2: w.part_2 = 5'd31;
            3: w.part_3 = 0;
            4: w.part_4 = 5'(cur_limit + 1);
            5: w.part_5 = 5'd31;
            6: w.part_6 = 0;
            default: w.part_7 = 5'(cur_limit + 1);
         endcase
      end else begin
         w = noise_word();
      end
      return w;
   endfunction

   // hold start across bursts; drop it only when a gap begins
   task automatic send_word(req_word_type w);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      start    <= 1'b1;
      req_word <= w;
      burst_left--;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_NUM_PARTS) cur_parts = (value % 16 < 1) ? 1 :
                                            (value % 16 > 8) ? 8 : value % 16;
      if (idx == REG_MAX_PART)  cur_limit = (value % 32 < 1) ? 1 :
                                            (value % 32 > 16) ? 16 : value % 32;
      // hold off until the table rebuild is done
      do @(posedge clock); while (busy);
   endtask

   task automatic send_rank(int a, int b, int c, int e, int rest);
      req_word_type w;
      w = noise_word();
      w.kind = KIND_RANK;
      w.part_0 = 5'(a); w.part_1 = 5'(b); w.part_2 = 5'(c); w.part_3 = 5'(e);
      w.part_4 = 5'(rest); w.part_5 = 5'(rest); w.part_6 = 5'(rest);
      w.part_7 = 5'(rest);
      send_word(w);
   endtask

   task automatic send_unrank(longint idx, int s);
      req_word_type w;
      w = noise_word();
      w.kind = KIND_UNRANK;
      w.rank_in = 32'(idx);
      w.total = 8'(s);
      send_word(w);
   endtask

   initial begin
      int settings [8][2];
      settings = '{'{1, 16}, '{8, 16}, '{8, 1}, '{0, 0}, '{15, 31},
                   '{3, 5}, '{2, 2}, '{4, 7}};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (busy);

      // directed words under reset settings: d = 4, k = 7
      send_rank(1, 1, 1, 1, 0);
      send_rank(7, 7, 7, 7, 31);
      send_rank(7, 1, 1, 1, 31);
      send_rank(1, 7, 3, 2, 0);
      send_rank(0, 3, 3, 3, 0);
      send_rank(3, 8, 3, 3, 0);
      send_rank(3, 3, 3, 31, 0);
      send_unrank(0, 4);
      send_unrank(0, 28);
      send_unrank(0, 3);
      send_unrank(0, 29);
      send_unrank(0, 255);
      send_unrank(32'hFFFF_FFFF, 16);
      send_unrank(vector_count(4, 7, 16) - 1, 16);
      send_unrank(vector_count(4, 7, 16), 16);
      send_unrank(vector_count(4, 7, 10) / 2, 10);

      // ignored register index, then a pass through the settings
      write_reg(REG_SPARE, 8'hFF);
      write_reg(REG_SPARE_HI, 8'h5A);
      for (int n = 0; n < 40; n++) send_word(random_word());
      foreach (settings[s]) begin
         write_reg(REG_NUM_PARTS, settings[s][0]);
         write_reg(REG_MAX_PART, settings[s][1]);
         if (s == 0) begin
            // single part: every legal rank is zero
            send_rank(16, 31, 31, 31, 31);
            send_unrank(0, 16);
         end
         for (int n = 0; n < 50; n++) send_word(random_word());
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
